/* rtl/core/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;
  localparam int STATUS_W      = 2;
  localparam int VAL_W         = 64;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OVF  = 2'd1,
    STATUS_DIV0 = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  // Decoded item as it sits in the queue
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic [DATA_W-1:0]  result;
    logic               compare;
    status_t            status;
  } entry_t;

  // Item in flight through the back end
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic [DATA_W-1:0]  result;
    logic               compare;
    status_t            status;
    logic [VAL_W-1:0]   val;
    logic [DATA_W-1:0]  rem;
    logic [DATA_W-1:0]  divisor;
  } stage_t;

endpackage

/* rtl/core/fpa_op_if.sv */
// ----------------------------------------------------------------------------
// fpa_op_if
// Operation channel: command and two raw fixed-point operands.
// ----------------------------------------------------------------------------
interface fpa_op_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

/* rtl/core/fpa_res_if.sv */
// ----------------------------------------------------------------------------
// fpa_res_if
// Result channel: raw result, compare outcome and status.
// ----------------------------------------------------------------------------
interface fpa_res_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_raw;
  logic                     compare_true;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, result_raw, compare_true, status, input ready);
  modport sink   (input valid, result_raw, compare_true, status, output ready);
endinterface

/* rtl/core/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Accepts operations, finishes the short ones and classifies mul and div.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  fpa_op_if.sink          operation,
  input  logic            push_ready,
  output logic            push_valid,
  output fpa_pkg::entry_t push_data
);
  import fpa_pkg::*;

  localparam int EXT_W = 2 * DATA_W - 1;
  localparam logic [EXT_W-1:0] NEG_MAG = EXT_W'(64'h8000_0000);
  localparam logic [EXT_W-1:0] POS_MAG = EXT_W'(64'h7FFF_FFFF);

  logic [DATA_W-1:0] a_u;
  logic [DATA_W-1:0] b_u;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W-1:0] ti_mag;
  logic [EXT_W-1:0]  fi_mag;
  logic              a_neg;
  logic              b_neg;
  cmd_t              cmd;
  entry_t            e;

  assign a_u    = operation.operand_a;
  assign b_u    = operation.operand_b;
  assign a_neg  = a_u[DATA_W-1];
  assign b_neg  = b_u[DATA_W-1];
  assign mag_a  = a_neg ? (DATA_W'(0) - a_u) : a_u;
  assign mag_b  = b_neg ? (DATA_W'(0) - b_u) : b_u;
  assign ti_mag = mag_a >> FRAC_BITS;
  assign fi_mag = {{(EXT_W-DATA_W){1'b0}}, mag_a} << FRAC_BITS;
  assign cmd    = cmd_t'(operation.cmd);

  always_comb begin
    e         = '0;
    e.kind    = KIND_DONE;
    e.status  = STATUS_OK;
    e.neg     = a_neg ^ b_neg;
    e.mag_a   = mag_a;
    e.mag_b   = mag_b;
    case (cmd)
      CMD_ADD: e.result = a_u + b_u;
      CMD_SUB: e.result = a_u - b_u;
      CMD_MUL: e.kind = KIND_MUL;
      CMD_DIV: begin
        if (b_u == '0) begin
          e.status = STATUS_DIV0;
          e.result = a_neg ? DATA_W'(64'h8000_0000) : DATA_W'(64'h7FFF_FFFF);
        end else begin
          e.kind = KIND_DIV;
        end
      end
      CMD_GT:  e.compare = operation.operand_a >  operation.operand_b;
      CMD_LT:  e.compare = operation.operand_a <  operation.operand_b;
      CMD_GE:  e.compare = operation.operand_a >= operation.operand_b;
      CMD_LE:  e.compare = operation.operand_a <= operation.operand_b;
      CMD_EQ:  e.compare = a_u == b_u;
      CMD_NE:  e.compare = a_u != b_u;
      // ties pick b
      CMD_MIN: e.result = (operation.operand_a < operation.operand_b) ? a_u : b_u;
      CMD_MAX: e.result = (operation.operand_a > operation.operand_b) ? a_u : b_u;
      CMD_INC: e.result = a_u + DATA_W'(1);
      CMD_DEC: e.result = a_u - DATA_W'(1);
      CMD_FROM_INT: begin
        if (a_neg) begin
          if (fi_mag > NEG_MAG) begin
            e.status = STATUS_OVF;
            e.result = DATA_W'(64'h8000_0000);
          end else begin
            e.result = DATA_W'(0) - fi_mag[DATA_W-1:0];
          end
        end else if (fi_mag > POS_MAG) begin
          e.status = STATUS_OVF;
          e.result = DATA_W'(64'h7FFF_FFFF);
        end else begin
          e.result = fi_mag[DATA_W-1:0];
        end
      end
      CMD_TO_INT: e.result = a_neg ? (DATA_W'(0) - ti_mag) : ti_mag;
      default: e.result = '0;
    endcase
  end

  assign push_valid      = operation.valid;
  assign push_data       = e;
  assign operation.ready = push_ready;

endmodule

/* rtl/core/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fpa_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fpa_pkg::entry_t pop_data
);
  import fpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  entry_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/fpa_div_stage.sv */
// ----------------------------------------------------------------------------
// fpa_div_stage
// One restoring step of the pipelined divider; other items pass through.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int NUM_W = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fpa_pkg::stage_t in_stage,
  output logic            out_valid,
  output fpa_pkg::stage_t out_stage
);
  import fpa_pkg::*;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;
  stage_t            step;

  // shift in the next dividend bit, subtract when the divisor fits
  assign trial = {in_stage.rem, in_stage.val[NUM_W-1]};
  assign diff  = trial - {1'b0, in_stage.divisor};
  assign fits  = trial >= {1'b0, in_stage.divisor};

  always_comb begin
    step = in_stage;
    if (in_stage.kind == KIND_DIV) begin
      step.rem            = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      step.val[NUM_W-1:0] = {in_stage.val[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= step;
    end
  end

endmodule

/* rtl/core/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Multiplier, pipelined divider and saturating output register.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  fpa_pkg::entry_t pop_data,
  fpa_res_if.source       result
);
  import fpa_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam logic [VAL_W-1:0] NEG_MAG = VAL_W'(64'h8000_0000);
  localparam logic [VAL_W-1:0] POS_MAG = VAL_W'(64'h7FFF_FFFF);

  logic               en;
  logic [VAL_W-1:0]   prod;
  stage_t             head;
  stage_t             head_q;
  logic               head_vld;
  stage_t             stg [NUM_W+1];
  logic [NUM_W:0]     vld;
  stage_t             last;
  logic [VAL_W-1:0]   mag;
  logic [DATA_W-1:0]  res_next;
  status_t            status_next;

  // advance the whole pipe whenever the output register is free
  assign en        = !result.valid || result.ready;
  assign pop_ready = en;

  assign prod = VAL_W'(pop_data.mag_a) * VAL_W'(pop_data.mag_b);

  always_comb begin
    head         = '0;
    head.kind    = pop_data.kind;
    head.neg     = pop_data.neg;
    head.result  = pop_data.result;
    head.compare = pop_data.compare;
    head.status  = pop_data.status;
    head.divisor = pop_data.mag_b;
    head.rem     = '0;
    head.val     = (pop_data.kind == KIND_MUL) ? prod
                 : ({{(VAL_W-DATA_W){1'b0}}, pop_data.mag_a} << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
    end else if (en) begin
      head_vld <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_q <= head;
    end
  end

  assign stg[0] = head_q;
  assign vld[0] = head_vld;

  for (genvar k = 1; k <= NUM_W; k++) begin : g_div
    fpa_div_stage #(.NUM_W(NUM_W)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[k-1]),
      .in_stage  (stg[k-1]),
      .out_valid (vld[k]),
      .out_stage (stg[k])
    );
  end

  assign last = stg[NUM_W];
  assign mag  = (last.kind == KIND_MUL) ? (last.val >> FRAC_BITS)
              : {{(VAL_W-NUM_W){1'b0}}, last.val[NUM_W-1:0]};

  always_comb begin
    res_next    = last.result;
    status_next = last.status;
    if (last.kind != KIND_DONE) begin
      if (last.neg) begin
        if (mag > NEG_MAG) begin
          res_next    = DATA_W'(64'h8000_0000);
          status_next = STATUS_OVF;
        end else begin
          res_next = DATA_W'(0) - mag[DATA_W-1:0];
        end
      end else if (mag > POS_MAG) begin
        res_next    = DATA_W'(64'h7FFF_FFFF);
        status_next = STATUS_OVF;
      end else begin
        res_next = mag[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.result_raw   <= res_next;
      result.compare_true <= last.compare;
      result.status       <= status_next;
    end
  end

endmodule

/* rtl/core/fixed_point_q24_8_alu_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed fixed-point ALU on 32-bit raw values, FRAC_BITS fraction bits.
// Every item traverses the one-quotient-bit-per-stage divider pipe between the
// head and output registers; the default FRAC_BITS gives Q24.8.
// Throughput: one item per cycle while the result channel does not stall; a two-entry queue parts front and back end.
// Reset (rst, synchronous): empties the queue and clears all valid flags.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fpa_op_if.sink    operation,
  fpa_res_if.source result
);
  import fpa_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .operation  (operation),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
